[rtl/cdq_pkg.sv]
// Package for the circular deque: sizes and operation codes.
`timescale 1ns / 1ps
package cdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 16;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = 11;
    localparam int OP_W   = 3;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [DATA_W-1:0] data_t;

endpackage

[rtl/circular_deque.sv]
// Circular deque: double-ended ring buffer of programmable capacity.
`timescale 1ns / 1ps
// For each command, the cycle it is accepted writes the item store and updates
// the pointers and count, the next cycle reads the front and rear slots from
// the store's two read ports, and the result follows as a one-cycle done
// strobe during which a new command may already be accepted. busy is high
// for the read cycle only. The receiver cannot stall: each result is valid only
// while done is high. Writing capacity (clamped to 1..1024) empties the deque;
// cfg_ready is low while busy or while start is high, so a command always wins.
// front_item and rear_item read zero when empty.
module circular_deque (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cdq_pkg::OP_W-1:0]     operation,
    input  logic [cdq_pkg::DATA_W-1:0]   value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cdq_pkg::CNT_W-1:0]    cfg_data,
    output logic                         done,
    output logic                         ok,
    output logic                         is_empty,
    output logic                         is_full,
    output logic [cdq_pkg::CNT_W-1:0]    item_count,
    output logic [cdq_pkg::DATA_W-1:0]   front_item,
    output logic [cdq_pkg::DATA_W-1:0]   rear_item
);
    import cdq_pkg::*;

    localparam count_t DEPTH_C = CNT_W'(DEPTH);

    data_t  mem [DEPTH];

    count_t cap_reg,   cap_next;
    slot_t  head_reg,  head_next;
    slot_t  tail_reg,  tail_next;
    count_t count_reg, count_next;
    logic   busy_reg,  done_reg, ok_reg, ok_next;
    data_t  front_reg, rear_reg;

    logic   accept, cfg_wr, st_full, st_empty, wr_en;
    slot_t  wr_addr, head_fwd, head_bwd, tail_fwd, tail_bwd;
    count_t cap_sat;

    function automatic slot_t slot_inc(slot_t s, count_t c);
        count_t s1;
        s1 = {1'b0, s} + 1'b1;
        return (s1 >= c) ? '0 : s1[SLOT_W-1:0];
    endfunction

    function automatic slot_t slot_dec(slot_t s, count_t c);
        count_t cm1;
        cm1 = c - 1'b1;
        return (s == '0) ? cm1[SLOT_W-1:0] : s - 1'b1;
    endfunction

    assign accept    = start && !busy_reg;
    assign cfg_ready = !busy_reg && !start;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign busy      = busy_reg;

    assign st_full  = (count_reg >= cap_reg);
    assign st_empty = (count_reg == '0);

    assign head_fwd = slot_inc(head_reg, cap_reg);
    assign head_bwd = slot_dec(head_reg, cap_reg);
    assign tail_fwd = slot_inc(tail_reg, cap_reg);
    assign tail_bwd = slot_dec(tail_reg, cap_reg);

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_sat = count_t'(1);
        end
        else if (cfg_data > DEPTH_C)
        begin
            cap_sat = DEPTH_C;
        end
        else
        begin
            cap_sat = cfg_data;
        end
    end

    always_comb
    begin
        cap_next   = cap_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        if (cfg_wr)
        begin
            cap_next   = cap_sat;
            head_next  = slot_dec('0, cap_sat);
            tail_next  = '0;
            count_next = '0;
        end
        else if (accept)
        begin
            ok_next = 1'b0;
            unique case (operation)
                OP_PUSH_FRONT:
                begin
                    if (!st_full)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_reg;
                        head_next  = head_bwd;
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (!st_full)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        tail_next  = tail_fwd;
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (!st_empty)
                    begin
                        head_next  = head_fwd;
                        count_next = count_reg - 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (!st_empty)
                    begin
                        tail_next  = tail_bwd;
                        count_next = count_reg - 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    ok_next = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= DEPTH_C;
            head_reg  <= slot_t'(DEPTH - 1);
            tail_reg  <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
            busy_reg  <= accept;
            done_reg  <= busy_reg;
        end
    end

    // item store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            front_reg <= mem[head_fwd];
            rear_reg  <= mem[tail_bwd];
        end
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign is_empty   = st_empty;
    assign is_full    = st_full;
    assign item_count = count_reg;
    assign front_item = st_empty ? '0 : front_reg;
    assign rear_item  = st_empty ? '0 : rear_reg;

endmodule
